// File: design/rbhe_pkg.sv
// shared types, constants and the brush step function of the heightmap editor
package rbhe_pkg;

	// coordinate of a visited cell: center plus offset, may go negative
	localparam int COORD_W = 10;
	// effective grid size, enough for the largest grid dimension
	localparam int DIM_W   = 13;
	// offset from the brush center, -63..63
	localparam int OFS_W   = 7;
	// squared offset, up to 63*63
	localparam int SQ_W    = 12;
	// squared distance, up to 2*63*63
	localparam int DIST_W  = 13;
	// brush step magnitude, up to 20
	localparam int STEP_W  = 5;
	// height of one cell
	localparam int HGT_W   = 8;

	localparam logic signed [HGT_W-1:0] HGT_MIN = -8'sd125;
	localparam logic signed [HGT_W-1:0] HGT_MAX = 8'sd125;

	// squared distances at or below this get the flat center step
	localparam logic [DIST_W-1:0]  NEAR_DIST = 13'd29;
	localparam logic [STEP_W-1:0]  NEAR_STEP = 5'd20;

	// step m reaches k when n <= floor(3599 / k*k), k = 1..10
	localparam int NUM_THR = 10;
	localparam logic [DIST_W-1:0] STEP_THR [NUM_THR] = '{
		13'd3599, 13'd899, 13'd399, 13'd224, 13'd143,
		13'd99, 13'd73, 13'd56, 13'd44, 13'd35
	};

	// register indexes on the config port
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_RAISE = 2'd1,
		MODE_LOWER = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ALU_SAT = 2'd0,
		ALU_ADD = 2'd1,
		ALU_SUB = 2'd2
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_EVAL,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// effective grid size seen by the sequencer
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} grid_dims_t;

	// step magnitude for squared distance n
	function automatic logic [STEP_W-1:0] brush_step(input logic [DIST_W-1:0] n);
		logic [STEP_W-1:0] m;
		m = '0;
		for (int k = 0; k < NUM_THR; k++) begin
			if (n <= STEP_THR[k]) begin
				m = m + STEP_W'(1);
			end
		end
		if (n <= NEAR_DIST) begin
			m = NEAR_STEP;
		end
		return m;
	endfunction

endpackage

// File: design/radial_brush_heightmap_editor.sv
// top level: sequencer walking cells through the shared height unit and the grid ram
//
// Heightmap editor with a command interface. An item is taken when start is high
// and busy is low; busy then stays high until the item's single result has been
// shown. The result is on cell_value for exactly one cycle while done is high and
// cannot be held off, so the receiver must take it then. A write goes through the
// write state to its result, a read through the read and read-wait states. A brush
// of radius r walks the (2r+1) by (2r+1) box around its center one cell at a time
// through a single-port grid memory: a cell outside the grid or the circle is only
// evaluated, a changed cell is evaluated (read) and then updated (write-back through
// the shared saturating adder), and the result follows the last cell. Cells never
// written read back undefined data. Config writes are taken at any time and should
// only be made while the block is not busy.
module radial_brush_heightmap_editor #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [7:0]        center_x,
	input  logic [7:0]        center_y,
	input  logic [5:0]        radius,
	input  logic signed [7:0] write_value,
	output logic              done,
	output logic signed [7:0] cell_value
);
	import rbhe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	grid_dims_t dims;

	state_t state_q, state_d;

	// item registers
	mode_t                      mode_q;
	logic [7:0]                 cx_q;
	logic [7:0]                 cy_q;
	logic [5:0]                 r_q;
	logic signed [HGT_W-1:0]    wv_q;
	logic [SQ_W-1:0]            r2_q;

	// walk registers
	logic signed [OFS_W-1:0]    dx_q;
	logic signed [OFS_W-1:0]    dy_q;
	logic [SQ_W-1:0]            dxsq_q;
	logic [SQ_W-1:0]            dysq_q;
	logic [AW-1:0]              addr_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [HGT_W-1:0]    result_q;

	// accept-time values
	logic                       accept;
	logic [5:0]                 r_clamp;
	logic [SQ_W-1:0]            r2_in;
	logic                       is_brush_in;

	// current cell
	logic signed [COORD_W-1:0]  cur_x;
	logic signed [COORD_W-1:0]  cur_y;
	logic                       cur_inside;
	logic [AW-1:0]              cur_addr;
	logic [DIST_W-1:0]          sq_dist;
	logic                       cur_hit;

	// walk advance
	logic signed [OFS_W-1:0]    r_signed;
	logic                       last_col;
	logic                       last_row;
	logic [SQ_W-1:0]            dxsq_inc;
	logic [SQ_W-1:0]            dysq_inc;

	// ram and alu hookup
	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic signed [HGT_W-1:0]    ram_wdata;
	logic [HGT_W-1:0]           ram_rdata;
	alu_op_t                    alu_op;
	logic signed [HGT_W-1:0]    alu_a;
	logic [STEP_W-1:0]          alu_step;
	logic signed [HGT_W-1:0]    alu_y;

	rbhe_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.dims   (dims)
	);

	rbhe_ram #(
		.WIDTH(HGT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	rbhe_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.step(alu_step),
		.y   (alu_y)
	);

	// item accept and radius clamp
	assign accept      = start && !busy;
	assign is_brush_in = (mode_t'(mode) == MODE_RAISE) || (mode_t'(mode) == MODE_LOWER);
	assign r_clamp     = ({3'b0, radius} > 9'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : radius;
	assign r2_in       = SQ_W'(r_clamp) * SQ_W'(r_clamp);

	// current cell position, grid check and address
	assign cur_x = $signed({2'b00, cx_q}) + COORD_W'(dx_q);
	assign cur_y = $signed({2'b00, cy_q}) + COORD_W'(dy_q);
	assign cur_inside = !cur_x[COORD_W-1] && !cur_y[COORD_W-1] &&
		({{(DIM_W-COORD_W+1){1'b0}}, cur_x[COORD_W-2:0]} < dims.width) &&
		({{(DIM_W-COORD_W+1){1'b0}}, cur_y[COORD_W-2:0]} < dims.height);
	assign cur_addr = AW'(int'(cur_y[COORD_W-2:0]) * MAX_WIDTH + int'(cur_x[COORD_W-2:0]));
	assign sq_dist  = {1'b0, dxsq_q} + {1'b0, dysq_q};
	assign cur_hit  = cur_inside && (sq_dist < {1'b0, r2_q});

	// box walk: next offset and its square from (d+1)^2 = d^2 + 2d + 1
	assign r_signed = $signed({1'b0, r_q});
	assign last_col = (dx_q == r_signed);
	assign last_row = (dy_q == r_signed);
	assign dxsq_inc = dxsq_q + SQ_W'($signed({dx_q, 1'b1}));
	assign dysq_inc = dysq_q + SQ_W'($signed({dy_q, 1'b1}));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_WRITE: state_d = ST_WRITE;
						MODE_READ:  state_d = ST_READ;
						default:    state_d = ST_EVAL;
					endcase
				end
			end
			ST_WRITE:     state_d = ST_DONE;
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_EVAL: begin
				if (cur_hit) begin
					state_d = ST_UPDATE;
				end else if (last_col && last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_UPDATE: begin
				if (last_col && last_row) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs, ram and alu control
	always_comb begin
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		ram_we    = 1'b0;
		ram_addr  = cur_addr;
		ram_wdata = alu_y;
		alu_op    = ALU_SAT;
		alu_a     = wv_q;
		alu_step  = step_q;
		case (state_q)
			ST_WRITE: begin
				ram_we = cur_inside;
			end
			ST_UPDATE: begin
				ram_we   = 1'b1;
				ram_addr = addr_q;
				alu_a    = $signed(ram_rdata);
				alu_op   = (mode_q == MODE_LOWER) ? ALU_SUB : ALU_ADD;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign cell_value = result_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(mode);
			cx_q     <= center_x;
			cy_q     <= center_y;
			r_q      <= r_clamp;
			wv_q     <= write_value;
			r2_q     <= r2_in;
			result_q <= '0;
			if (is_brush_in) begin
				dx_q   <= -$signed({1'b0, r_clamp});
				dy_q   <= -$signed({1'b0, r_clamp});
				dxsq_q <= r2_in;
				dysq_q <= r2_in;
			end else begin
				dx_q   <= '0;
				dy_q   <= '0;
				dxsq_q <= '0;
				dysq_q <= '0;
			end
		end

		// read result
		if (state_q == ST_READ_WAIT) begin
			result_q <= cur_inside ? $signed(ram_rdata) : '0;
		end

		// hit cell: keep address and step for write-back
		if ((state_q == ST_EVAL) && cur_hit) begin
			addr_q <= cur_addr;
			step_q <= brush_step(sq_dist);
		end

		// move to the next cell of the box
		if (((state_q == ST_EVAL) && !cur_hit) || (state_q == ST_UPDATE)) begin
			if (last_col) begin
				dx_q   <= -r_signed;
				dxsq_q <= r2_q;
				if (!last_row) begin
					dy_q   <= dy_q + OFS_W'(1);
					dysq_q <= dysq_inc;
				end
			end else begin
				dx_q   <= dx_q + OFS_W'(1);
				dxsq_q <= dxsq_inc;
			end
		end
	end

endmodule

// File: design/rbhe_ram.sv
// generic single-port ram with registered read
module rbhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/rbhe_cfg.sv
// apb config registers for grid width and height, clamped to the grid maximum
module rbhe_cfg #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output rbhe_pkg::grid_dims_t dims
);
	import rbhe_pkg::*;

	logic [8:0] grid_width_q;
	logic [8:0] grid_height_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 9'd256;
			grid_height_q <= 9'd256;
		end else if (wr_en) begin
			if (reg_sel == REG_GRID_WIDTH) begin
				grid_width_q <= pwdata[8:0];
			end else begin
				grid_height_q <= pwdata[8:0];
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_GRID_WIDTH) begin
			prdata[8:0] = grid_width_q;
		end else begin
			prdata[8:0] = grid_height_q;
		end
	end

	// clamp to the grid size that the memory holds
	always_comb begin
		dims.width  = {4'b0, grid_width_q};
		dims.height = {4'b0, grid_height_q};
		if (dims.width > DIM_W'(MAX_WIDTH)) begin
			dims.width = DIM_W'(MAX_WIDTH);
		end
		if (dims.height > DIM_W'(MAX_HEIGHT)) begin
			dims.height = DIM_W'(MAX_HEIGHT);
		end
	end

endmodule

// File: design/rbhe_alu.sv
// shared height unit: saturating add or subtract of a step, or plain saturation
module rbhe_alu (
	input  rbhe_pkg::alu_op_t                      op,
	input  logic signed [rbhe_pkg::HGT_W-1:0]      a,
	input  logic        [rbhe_pkg::STEP_W-1:0]     step,
	output logic signed [rbhe_pkg::HGT_W-1:0]      y
);
	import rbhe_pkg::*;

	logic signed [HGT_W+1:0] sum;
	logic signed [HGT_W+1:0] b_ext;

	assign b_ext = $signed({{(HGT_W+2-STEP_W){1'b0}}, step});

	// add or subtract the step in a widened word
	always_comb begin
		case (op)
			ALU_ADD: sum = {{2{a[HGT_W-1]}}, a} + b_ext;
			ALU_SUB: sum = {{2{a[HGT_W-1]}}, a} - b_ext;
			ALU_SAT: sum = {{2{a[HGT_W-1]}}, a};
			default: sum = {{2{a[HGT_W-1]}}, a};
		endcase
	end

	// clamp to the height range
	always_comb begin
		if (sum < $signed({{2{HGT_MIN[HGT_W-1]}}, HGT_MIN})) begin
			y = HGT_MIN;
		end else if (sum > $signed({2'b00, HGT_MAX})) begin
			y = HGT_MAX;
		end else begin
			y = sum[HGT_W-1:0];
		end
	end

endmodule

// File: dv/testbench.sv
// self-checking testbench for the radial brush heightmap editor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rbhe_pkg::*;

	localparam int GRID_SIDE   = 256;
	localparam int REPORT_MAX  = 10;
	localparam int CYCLE_LIMIT = 2_500_000;
	// working area that is filled before any read or brush
	localparam int FILL_COLS   = 16;
	localparam int FILL_ROWS   = 2;

	// one edit command plus the idle cycles that go before it
	typedef struct {
		mode_t             op;
		logic [7:0]        x;
		logic [7:0]        y;
		logic [5:0]        r;
		logic signed [7:0] v;
		int unsigned       gap;
	} edit_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [2:0]        paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start   = 1'b0;
	logic              busy;
	mode_t             mode        = MODE_WRITE;
	logic [7:0]        center_x    = '0;
	logic [7:0]        center_y    = '0;
	logic [5:0]        radius      = '0;
	logic signed [7:0] write_value = '0;
	logic              done;
	logic signed [7:0] cell_value;

	// shadow copy of the grid and of the size registers
	logic signed [7:0] height_map [GRID_SIDE*GRID_SIDE];
	int unsigned       grid_cols = 256;
	int unsigned       grid_rows = 256;

	edit_t             pending_edits [$];
	logic signed [7:0] expected_cells [$];
	edit_t             active_edit;
	int unsigned       idle_left  = 0;
	logic              gap_served = 1'b0;
	int                errors     = 0;
	int unsigned       cycle_count = 0;

	radial_brush_heightmap_editor i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.write_value (write_value),
		.done        (done),
		.cell_value  (cell_value)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int eff_dim(input int unsigned d);
		return (d > GRID_SIDE) ? GRID_SIDE : int'(d);
	endfunction

	function automatic logic signed [7:0] clamp_height(input int lvl);
		if (lvl < -125) return -8'sd125;
		if (lvl > 125) return 8'sd125;
		return lvl[7:0];
	endfunction

	// flat step near the center, then largest m with m*m*n below 3600
	function automatic int step_for(input int n);
		int m;
		m = 0;
		if (n <= 29) return 20;
		while ((m + 1) * (m + 1) * n < 3600) m++;
		return m;
	endfunction

	// update the shadow grid for one edit and return the cell value it answers
	function automatic logic signed [7:0] apply_edit(input edit_t e);
		int cols, rows, x0, y0, k, i, j, dx, dy, n, lvl, idx;
		logic signed [7:0] answer;
		cols = eff_dim(grid_cols);
		rows = eff_dim(grid_rows);
		x0 = e.x;
		y0 = e.y;
		k = e.r;
		answer = '0;
		case (e.op)
			MODE_WRITE: begin
				if (x0 < cols && y0 < rows) height_map[y0*GRID_SIDE + x0] = clamp_height(e.v);
			end
			MODE_READ: begin
				if (x0 < cols && y0 < rows) answer = height_map[y0*GRID_SIDE + x0];
			end
			default: begin
				// walk the box, skip cells off the grid or outside the circle
				for (j = y0 - k; j <= y0 + k; j++) begin
					if (j < 0 || j >= rows) continue;
					for (i = x0 - k; i <= x0 + k; i++) begin
						if (i < 0 || i >= cols) continue;
						dx = i - x0;
						dy = j - y0;
						n = dx*dx + dy*dy;
						if (n >= k*k) continue;
						idx = j*GRID_SIDE + i;
						lvl = height_map[idx];
						lvl = (e.op == MODE_LOWER) ? lvl - step_for(n) : lvl + step_for(n);
						height_map[idx] = clamp_height(lvl);
					end
				end
			end
		endcase
		return answer;
	endfunction

	// mostly back to back, some short pauses, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// small brushes keep the run short, a few reach the maximum
	function automatic int pick_radius();
		if ($urandom_range(0, 99) < 3) return $urandom_range(32, 63);
		return $urandom_range(0, 9);
	endfunction

	function automatic int pick_coord(input int lim);
		if (lim > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, lim - 1);
		return $urandom_range(0, 255);
	endfunction

	function automatic int near(input int c, input int spread);
		int p;
		p = c + int'($urandom_range(0, 2*spread)) - spread;
		if (p < 0) p = 0;
		if (p > 255) p = 255;
		return p;
	endfunction

	task automatic push_edit(input mode_t op, input int x, input int y, input int r,
			input int v, input bit quiet);
		edit_t e;
		e.op = op;
		e.x = x[7:0];
		e.y = y[7:0];
		e.r = r[5:0];
		e.v = v[7:0];
		e.gap = quiet ? 0 : pick_gap();
		pending_edits.push_back(e);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_edits.size() != 0 || start || busy || expected_cells.size() != 0);
	endtask

	// register write: setup phase, then access phase
	task automatic reg_write(input logic reg_idx, input logic [8:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_GRID_WIDTH) grid_cols = value;
		else grid_rows = value;
	endtask

	task automatic set_grid(input logic [8:0] cols, input logic [8:0] rows);
		wait_idle();
		reg_write(REG_GRID_WIDTH, cols);
		reg_write(REG_GRID_HEIGHT, rows);
	endtask

	// brush sequences (an optional write, a brush, reads around it) mixed with loose commands
	task automatic random_burst(input int count, input bit quiet);
		int left, x, y, r, reads;
		mode_t op;
		left = count;
		while (left > 0) begin
			x = pick_coord(eff_dim(grid_cols));
			y = pick_coord(eff_dim(grid_rows));
			if ($urandom_range(0, 99) < 60) begin
				r = pick_radius();
				if ($urandom_range(0, 2) == 0) begin
					push_edit(MODE_WRITE, x, y, $urandom_range(0, 63), $urandom_range(0, 255), quiet);
					left--;
				end
				op = $urandom_range(0, 1) ? MODE_RAISE : MODE_LOWER;
				push_edit(op, x, y, r, $urandom_range(0, 255), quiet);
				reads = $urandom_range(1, 3);
				repeat (reads) begin
					push_edit(MODE_READ, near(x, r + 1), near(y, r + 1), $urandom_range(0, 63),
						$urandom_range(0, 255), quiet);
				end
				left -= reads + 1;
			end else begin
				op = mode_t'($urandom_range(0, 3));
				push_edit(op, x, y, pick_radius(), $urandom_range(0, 255), quiet);
				left--;
			end
		end
	endtask

	// command driver: holds start until the beat is taken, then predicts it
	always @(posedge clk or negedge arst_n) begin : drive_edits
		logic keep_start;
		if (!arst_n) begin
			start      <= 1'b0;
			idle_left  <= 0;
			gap_served <= 1'b0;
		end else begin
			keep_start = start && busy;
			if (start && !busy) expected_cells.push_back(apply_edit(active_edit));
			if (!keep_start) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					start     <= 1'b0;
				end else if (pending_edits.size() != 0 && !gap_served && pending_edits[0].gap != 0) begin
					idle_left  <= pending_edits[0].gap - 1;
					gap_served <= 1'b1;
					start      <= 1'b0;
				end else if (pending_edits.size() != 0) begin
					active_edit = pending_edits.pop_front();
					mode        <= active_edit.op;
					center_x    <= active_edit.x;
					center_y    <= active_edit.y;
					radius      <= active_edit.r;
					write_value <= active_edit.v;
					start       <= 1'b1;
					gap_served  <= 1'b0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// score each result beat against the oldest expected height
	always @(posedge clk) begin : score_results
		logic signed [7:0] want;
		if (arst_n && done) begin
			if (expected_cells.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) $display("unexpected result beat: cell_value %0d", cell_value);
			end else begin
				want = expected_cells.pop_front();
				if (cell_value !== want) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("cell_value mismatch: expected %0d, got %0d", want, cell_value);
				end
			end
		end
	end

	initial begin
		foreach (height_map[idx]) height_map[idx] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// fill the working area so no read or brush meets undefined memory
		set_grid(9'(FILL_COLS), 9'(FILL_ROWS));
		for (int row = 0; row < FILL_ROWS; row++) begin
			for (int col = 0; col < FILL_COLS; col++) begin
				push_edit(MODE_WRITE, col, row, $urandom_range(0, 63),
					$urandom_range(0, 255), 1'b1);
			end
		end
		wait_idle();

		// write values beyond the range saturate, corners of the grid
		push_edit(MODE_WRITE, 0, 0, 0, 127, 1'b0);
		push_edit(MODE_READ, 0, 0, 0, 0, 1'b0);
		push_edit(MODE_WRITE, 15, 1, 63, -128, 1'b0);
		push_edit(MODE_READ, 15, 1, 63, 0, 1'b0);
		push_edit(MODE_WRITE, 15, 0, 0, -125, 1'b0);
		push_edit(MODE_READ, 15, 0, 0, 0, 1'b0);
		// raise and lower clamp at the height limits, radius zero changes nothing
		push_edit(MODE_WRITE, 5, 1, 0, 120, 1'b0);
		push_edit(MODE_RAISE, 5, 1, 3, 0, 1'b0);
		push_edit(MODE_READ, 5, 1, 0, 0, 1'b0);
		push_edit(MODE_LOWER, 5, 1, 0, 0, 1'b0);
		push_edit(MODE_READ, 5, 1, 0, 0, 1'b0);
		push_edit(MODE_WRITE, 5, 1, 0, -120, 1'b0);
		push_edit(MODE_LOWER, 5, 1, 2, 0, 1'b0);
		push_edit(MODE_READ, 5, 1, 0, 0, 1'b0);
		// largest brush: flat center, then the falloff steps
		push_edit(MODE_RAISE, 0, 0, 63, 0, 1'b0);
		push_edit(MODE_READ, 5, 0, 0, 0, 1'b0);
		push_edit(MODE_READ, 5, 1, 0, 0, 1'b0);
		push_edit(MODE_READ, 6, 0, 0, 0, 1'b0);
		push_edit(MODE_READ, 15, 1, 0, 0, 1'b0);
		// far ring: step of one, then zero once n reaches 3600
		push_edit(MODE_LOWER, 0, 60, 63, 0, 1'b0);
		push_edit(MODE_READ, 10, 1, 0, 0, 1'b0);
		push_edit(MODE_READ, 11, 1, 0, 0, 1'b0);
		// rim of a small brush just inside and outside
		push_edit(MODE_RAISE, 0, 0, 10, 0, 1'b0);
		push_edit(MODE_READ, 9, 1, 0, 0, 1'b0);
		push_edit(MODE_READ, 10, 0, 0, 0, 1'b0);
		push_edit(MODE_READ, 10, 1, 0, 0, 1'b0);
		// largest brush clipped by the grid corner
		push_edit(MODE_LOWER, 15, 1, 63, 0, 1'b0);
		push_edit(MODE_READ, 12, 0, 0, 0, 1'b0);
		push_edit(MODE_RAISE, 0, 0, 1, 0, 1'b0);
		push_edit(MODE_READ, 0, 0, 0, 0, 1'b0);
		push_edit(MODE_READ, 1, 0, 0, 0, 1'b0);

		// one-cell grid: cells outside are ignored or read as zero
		set_grid(9'd1, 9'd1);
		push_edit(MODE_WRITE, 0, 0, 0, 5, 1'b0);
		push_edit(MODE_WRITE, 1, 0, 0, 9, 1'b0);
		push_edit(MODE_READ, 1, 0, 0, 0, 1'b0);
		push_edit(MODE_RAISE, 0, 0, 4, 0, 1'b0);
		push_edit(MODE_READ, 0, 0, 0, 0, 1'b0);
		push_edit(MODE_READ, 0, 1, 0, 0, 1'b0);

		// empty grid: nothing changes, reads answer zero
		set_grid(9'd0, 9'd0);
		push_edit(MODE_WRITE, 0, 0, 0, 50, 1'b0);
		push_edit(MODE_RAISE, 3, 3, 10, 0, 1'b0);
		push_edit(MODE_READ, 0, 0, 0, 0, 1'b0);

		// oversized grid saturates to the full size
		set_grid(9'd511, 9'd300);
		push_edit(MODE_WRITE, 255, 255, 0, -7, 1'b0);
		push_edit(MODE_READ, 255, 255, 0, 0, 1'b0);
		push_edit(MODE_READ, 15, 1, 0, 0, 1'b0);

		// random phases over grid sizes inside the working area
		set_grid(9'(FILL_COLS), 9'(FILL_ROWS));
		random_burst(8, 1'b1);
		set_grid(9'($urandom_range(1, FILL_COLS)), 9'($urandom_range(1, FILL_ROWS)));
		random_burst(8, 1'b0);
		set_grid(9'(FILL_COLS), 9'd1);
		random_burst(8, 1'b0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
